// ----- rtl/core/prafu_pkg.sv -----
// ----------------------------------------------------------------------------
// prafu_pkg
// Types, codes and constants shared by the page run allocator modules.
// ----------------------------------------------------------------------------
package prafu_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int PAGE_W    = 12;
    localparam int IDX_W     = 13;
    localparam int ENTRY_W   = 24;
    localparam int FRAME_W   = 2;

    localparam logic [11:0] RESV_MASK  = 12'hE00;
    localparam logic [11:0] RESV_BIT   = 12'h200;
    localparam logic [11:0] FREE_KEEP  = 12'h1FE;
    localparam logic [11:0] BOOT_PAGES = 12'h603;
    localparam logic [11:0] BOOT_FLAGS = 12'h307;
    localparam logic [11:0] REST_FLAGS = 12'h006;

    localparam logic [1:0] FR_NONE = 2'd0;
    localparam logic [1:0] FR_USED = 2'd1;
    localparam logic [1:0] FR_FREE = 2'd2;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_FAULT = 2'd2;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FAILED   = 3'd1;
    localparam logic [2:0] ST_NOACT    = 3'd2;
    localparam logic [2:0] ST_FATAL    = 3'd3;
    localparam logic [2:0] ST_NOFRAME  = 3'd4;
    localparam logic [2:0] ST_IGNORED  = 3'd5;

    localparam logic [1:0] CFG_MEM_PAGES    = 2'd0;
    localparam logic [1:0] CFG_KERNEL_PAGES = 2'd1;
    localparam logic [1:0] CFG_FIRST_FREE   = 2'd2;
    localparam logic [1:0] CFG_GUARD_PAGE   = 2'd3;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_FREAD,
        S_FCHK,
        S_FSCAN
    } state_t;

endpackage

// ----- rtl/core/page_run_allocator_with_demand_fault_unit.sv -----
// ----------------------------------------------------------------------------
// page_run_allocator_with_demand_fault_unit
// First-fit page run allocator with free and demand-fault frame mapping.
// ----------------------------------------------------------------------------
// Rejected requests are answered from idle with no walk. Allocate walks pages
// from first_free_page and then marks the run it found; free walks the pages
// freed; a fault reads the page entry, checks it, then walks frames. These
// walks run at one table entry a cycle through the memory read port, and one
// item is worked at a time. After reset a fill pass initializes both tables
// while busy stays high. Results are strobed for one cycle; the receiver
// cannot stall.
module page_run_allocator_with_demand_fault_unit
    import prafu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           req_type,
    input  logic [12:0]          page_count,
    input  logic [11:0]          page_index,
    input  logic [23:0]          fault_address,
    input  logic [4:0]           fault_code,
    output logic                 done,
    output logic [2:0]           status,
    output logic [23:0]          result_address,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [12:0]          cfg_wdata
);

    state_t state_reg, state_next;

    logic [11:0]        mem_pages_reg;
    logic [12:0]        kernel_pages_reg;
    logic [11:0]        first_free_reg;
    logic [11:0]        guard_page_reg;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   end_reg, end_next;
    logic [IDX_W-1:0]   run_reg, run_next;
    logic [PAGE_W-1:0]  start_reg, start_next;
    logic [PAGE_W-1:0]  pidx_reg, pidx_next;
    logic               rv_reg, rv_next;
    logic [IDX_W-1:0]   count_reg, count_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [ENTRY_W-1:0] entry_reg, entry_next;

    logic               done_reg, done_next;
    logic [2:0]         status_reg, status_next;
    logic [23:0]        addr_reg, addr_next;

    logic               pg_we, fr_we;
    logic [PAGE_W-1:0]  pg_waddr, pg_raddr, fr_waddr;
    logic [ENTRY_W-1:0] pg_wdata, pg_rdata;
    logic [FRAME_W-1:0] fr_wdata, fr_rdata;

    logic               accept;
    logic               pg_unres;
    logic               alloc_hit, alloc_exhaust, kernel_fail;
    logic [PAGE_W-1:0]  run_start;
    logic               walk_end;
    logic               fscan_hit, fscan_end;
    logic [IDX_W:0]     free_sum;
    logic [PAGE_W-1:0]  fault_page;

    prafu_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_PAGES)) u_page_ram
    (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .raddr (pg_raddr),
        .rdata (pg_rdata)
    );

    prafu_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_PAGES)) u_frame_ram
    (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .raddr (idx_reg[PAGE_W-1:0]),
        .rdata (fr_rdata)
    );

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && (state_reg == S_IDLE);
    assign fault_page = fault_address[23:12];
    assign free_sum   = {2'b00, page_index} + {1'b0, page_count};

    assign pg_unres  = ((pg_rdata[11:0] & RESV_MASK) == 12'h000);
    assign run_start = (run_reg == '0) ? pidx_reg : start_reg;
    assign alloc_hit = rv_reg && pg_unres
                       && ((run_reg + IDX_W'(1)) == count_reg);
    assign kernel_fail   = ({1'b0, run_start} >= kernel_pages_reg);
    assign alloc_exhaust = (idx_reg == IDX_W'(NUM_PAGES)) && !rv_reg;
    assign walk_end      = (idx_reg == end_reg) && !rv_reg;
    assign fscan_hit     = rv_reg && (fr_rdata == FR_FREE);
    assign fscan_end     = (idx_reg > {1'b0, mem_pages_reg}) && !rv_reg;

    assign done           = done_reg;
    assign status         = status_reg;
    assign result_address = addr_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (idx_reg == IDX_W'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_ALLOC:
                        begin
                            if (page_count != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_FREE:
                        begin
                            if (page_index >= guard_page_reg)
                            begin
                                state_next = S_FREE;
                            end
                        end
                        REQ_FAULT:
                        begin
                            if (!fault_code[0] && fault_page >= guard_page_reg)
                            begin
                                state_next = S_FREAD;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (alloc_hit)
                begin
                    state_next = kernel_fail ? S_IDLE : S_MARK;
                end
                else if (alloc_exhaust)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MARK, S_FREE:
            begin
                if (walk_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FREAD: state_next = S_FCHK;
            S_FCHK:  state_next = pg_unres ? S_IDLE : S_FSCAN;
            S_FSCAN:
            begin
                if (fscan_hit || fscan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        idx_next    = idx_reg;
        end_next    = end_reg;
        run_next    = run_reg;
        start_next  = start_reg;
        pidx_next   = idx_reg[PAGE_W-1:0];
        rv_next     = 1'b0;
        count_next  = count_reg;
        page_next   = page_reg;
        entry_next  = entry_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        addr_next   = addr_reg;
        pg_we       = 1'b0;
        pg_waddr    = pidx_reg;
        pg_wdata    = pg_rdata;
        pg_raddr    = idx_reg[PAGE_W-1:0];
        fr_we       = 1'b0;
        fr_waddr    = pidx_reg;
        fr_wdata    = FR_FREE;

        case (state_reg)
            S_INIT:
            begin
                pg_we    = 1'b1;
                pg_waddr = idx_reg[PAGE_W-1:0];
                pg_wdata = {idx_reg[PAGE_W-1:0],
                            (idx_reg[PAGE_W-1:0] < BOOT_PAGES) ? BOOT_FLAGS : REST_FLAGS};
                fr_we    = 1'b1;
                fr_waddr = idx_reg[PAGE_W-1:0];
                fr_wdata = (idx_reg[PAGE_W-1:0] < BOOT_PAGES) ? FR_USED : FR_FREE;
                idx_next = idx_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    count_next = page_count;
                    run_next   = '0;
                    addr_next  = '0;
                    idx_next   = {1'b0, first_free_reg};
                    page_next  = fault_page;
                    case (req_type)
                        REQ_ALLOC:
                        begin
                            if (page_count == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FAILED;
                            end
                        end
                        REQ_FREE:
                        begin
                            idx_next = {1'b0, page_index};
                            end_next = (free_sum > (IDX_W + 1)'(NUM_PAGES))
                                       ? IDX_W'(NUM_PAGES) : free_sum[IDX_W-1:0];
                            if (page_index < guard_page_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_IGNORED;
                            end
                        end
                        REQ_FAULT:
                        begin
                            if (fault_code[0] || fault_page < guard_page_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FATAL;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOACT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg < IDX_W'(NUM_PAGES))
                begin
                    rv_next  = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                end
                if (rv_reg)
                begin
                    if (pg_unres)
                    begin
                        start_next = run_start;
                        run_next   = run_reg + IDX_W'(1);
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                if (alloc_hit)
                begin
                    rv_next  = 1'b0;
                    idx_next = {1'b0, run_start};
                    end_next = {1'b0, run_start} + count_reg;
                    if (kernel_fail)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_FAILED;
                    end
                end
                else if (alloc_exhaust)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FAILED;
                end
            end
            S_MARK, S_FREE:
            begin
                if (idx_reg < end_reg)
                begin
                    rv_next  = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                end
                if (rv_reg)
                begin
                    pg_we = 1'b1;
                    if (state_reg == S_MARK)
                    begin
                        pg_wdata = {pg_rdata[23:12], pg_rdata[11:0] | RESV_BIT};
                    end
                    else
                    begin
                        pg_wdata = {12'h000, pg_rdata[11:0] & FREE_KEEP};
                        fr_we    = 1'b1;
                    end
                end
                if (walk_end)
                begin
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    addr_next   = (state_reg == S_MARK) ? {start_reg, 12'h000} : 24'h0;
                end
            end
            S_FREAD:
            begin
                pg_raddr = page_reg;
            end
            S_FCHK:
            begin
                entry_next = pg_rdata;
                if (pg_unres)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOACT;
                end
            end
            S_FSCAN:
            begin
                if (idx_reg <= {1'b0, mem_pages_reg})
                begin
                    rv_next  = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                end
                if (fscan_hit)
                begin
                    fr_we       = 1'b1;
                    fr_wdata    = FR_USED;
                    pg_we       = 1'b1;
                    pg_waddr    = page_reg;
                    pg_wdata    = {pidx_reg, entry_reg[11:1], 1'b1};
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    addr_next   = {pidx_reg, 12'h000};
                end
                else if (fscan_end)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOFRAME;
                end
            end
            default:
            begin
                rv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            idx_reg          <= '0;
            rv_reg           <= 1'b0;
            done_reg         <= 1'b0;
            mem_pages_reg    <= 12'd4095;
            kernel_pages_reg <= 13'd4096;
            first_free_reg   <= 12'd1539;
            guard_page_reg   <= 12'd256;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rv_reg    <= rv_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_MEM_PAGES:    mem_pages_reg    <= cfg_wdata[11:0];
                    CFG_KERNEL_PAGES: kernel_pages_reg <= cfg_wdata;
                    CFG_FIRST_FREE:   first_free_reg   <= cfg_wdata[11:0];
                    CFG_GUARD_PAGE:   guard_page_reg   <= cfg_wdata[11:0];
                    default:          guard_page_reg   <= guard_page_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg    <= end_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        pidx_reg   <= pidx_next;
        count_reg  <= count_next;
        page_reg   <= page_next;
        entry_reg  <= entry_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
    end

endmodule

// ----- rtl/core/prafu_ram.sv -----
// ----------------------------------------------------------------------------
// prafu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module prafu_ram
    import prafu_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = NUM_PAGES
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
